@@ rtl/serial_command_frame_parser_defines.svh @@
// ----------------------------------------------------------------------------
// Serial command frame parser assertion macros
// Shared forms for the concurrent checks of the frame parser.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_FRAME_PARSER_DEFINES_SVH
`define SERIAL_COMMAND_FRAME_PARSER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SCFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame parser check failed in the same cycle");

// Checks that the consequent holds in the cycle after the antecedent.
`define SCFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame parser check failed in the following cycle");

`endif

@@ rtl/scfp_pkg.sv @@
// ----------------------------------------------------------------------------
// Serial command frame parser package
// Types, codes and reset constants shared by the parser and its channels.
// ----------------------------------------------------------------------------
package scfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 16;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SIZE_HI = 3'd1,
        PH_SIZE_LO = 3'd2,
        PH_OPCODE  = 3'd3,
        PH_FLAG    = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_DATA  = 2'd1,
        EV_EMPTY = 2'd2,
        EV_ABORT = 2'd3
    } event_kind_t;

    typedef enum logic {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } req_type_t;

    typedef enum logic {
        CFG_START_MARKER  = 1'b0,
        CFG_TIMEOUT_TICKS = 1'b1
    } cfg_index_t;

    localparam byte_t  START_MARKER_RESET  = 8'h00;
    localparam count_t TIMEOUT_TICKS_RESET = 16'd1000;
    localparam count_t IDLE_TICKS_MAX      = 16'hFFFF;

endpackage

@@ rtl/scfp_req_if.sv @@
// ----------------------------------------------------------------------------
// Frame parser request channel
// Carries received bytes and time ticks into the parser.
// ----------------------------------------------------------------------------
interface scfp_req_if;
    logic                valid;
    logic                ready;
    scfp_pkg::req_type_t req_type;
    scfp_pkg::byte_t     rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

@@ rtl/scfp_evt_if.sv @@
// ----------------------------------------------------------------------------
// Frame parser event channel
// Carries one parser event per request out of the parser.
// ----------------------------------------------------------------------------
interface scfp_evt_if;
    logic                  valid;
    logic                  ready;
    scfp_pkg::event_kind_t event_kind;
    scfp_pkg::byte_t       frame_opcode;
    scfp_pkg::byte_t       frame_flag;
    scfp_pkg::count_t      frame_size;
    scfp_pkg::byte_t       payload_byte;
    scfp_pkg::count_t      payload_index;
    logic                  last_of_frame;
    scfp_pkg::count_t      bytes_received;

    modport source (
        output valid, output event_kind, output frame_opcode, output frame_flag,
        output frame_size, output payload_byte, output payload_index,
        output last_of_frame, output bytes_received, input ready
    );
    modport sink (
        input valid, input event_kind, input frame_opcode, input frame_flag,
        input frame_size, input payload_byte, input payload_index,
        input last_of_frame, input bytes_received, output ready
    );
endinterface

@@ rtl/scfp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Frame parser configuration channel
// Register writes: an index and sixteen bits of write data.
// ----------------------------------------------------------------------------
interface scfp_cfg_if;
    logic                 valid;
    logic                 ready;
    scfp_pkg::cfg_index_t index;
    scfp_pkg::count_t     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/serial_command_frame_parser.sv @@
// ----------------------------------------------------------------------------
// Serial command frame parser
// Finds frames in a byte stream and streams out their payload bytes.
// ----------------------------------------------------------------------------
// The parser takes one request per cycle and gives exactly one event for each,
// in the cycle after the request transfer. The frame state updates in that same
// cycle, so the next request can follow directly; the only stall comes from
// the single event register, and req.ready drops only while that register is
// full and evt.ready is low. Register writes are always taken.
module serial_command_frame_parser (
    input  logic       clk,
    input  logic       rst_n,
    scfp_cfg_if.sink   cfg,
    scfp_req_if.sink   req,
    scfp_evt_if.source evt
);
    import scfp_pkg::*;

    byte_t       start_marker_reg;
    count_t      timeout_ticks_reg;

    phase_t      phase_reg,    phase_next;
    count_t      size_reg,     size_next;
    byte_t       opcode_reg,   opcode_next;
    byte_t       flag_reg,     flag_next;
    count_t      count_reg,    count_next;
    count_t      idle_reg,     idle_next;
    count_t      total_reg,    total_next;

    logic        evt_valid_reg;
    event_kind_t kind_reg,     kind_next;
    byte_t       ev_opcode_reg, ev_opcode_next;
    byte_t       ev_flag_reg,  ev_flag_next;
    count_t      ev_size_reg,  ev_size_next;
    byte_t       data_reg,     data_next;
    count_t      index_reg,    index_next;
    logic        last_reg,     last_next;

    logic        req_fire;
    count_t      idle_inc;
    logic [COUNT_W:0] count_plus;

    assign cfg.ready = 1'b1;
    assign req.ready = !evt_valid_reg || evt.ready;
    assign req_fire  = req.valid && req.ready;

    assign evt.valid          = evt_valid_reg;
    assign evt.event_kind     = kind_reg;
    assign evt.frame_opcode   = ev_opcode_reg;
    assign evt.frame_flag     = ev_flag_reg;
    assign evt.frame_size     = ev_size_reg;
    assign evt.payload_byte   = data_reg;
    assign evt.payload_index  = index_reg;
    assign evt.last_of_frame  = last_reg;
    assign evt.bytes_received = total_reg;

    assign idle_inc   = (idle_reg == IDLE_TICKS_MAX) ? idle_reg : idle_reg + 1'b1;
    assign count_plus = {1'b0, count_reg} + 1'b1;

    always_comb
    begin
        phase_next     = phase_reg;
        size_next      = size_reg;
        opcode_next    = opcode_reg;
        flag_next      = flag_reg;
        count_next     = count_reg;
        idle_next      = idle_reg;
        total_next     = total_reg;
        kind_next      = EV_NONE;
        data_next      = '0;
        index_next     = '0;
        last_next      = 1'b0;

        if (req.req_type == REQ_TICK)
        begin
            if (phase_reg == PH_HUNT)
            begin
                idle_next = '0;
            end
            else if (idle_inc > timeout_ticks_reg)
            begin
                kind_next  = EV_ABORT;
                index_next = count_reg;
                phase_next = PH_HUNT;
                count_next = '0;
                idle_next  = '0;
            end
            else
            begin
                idle_next = idle_inc;
            end
        end
        else
        begin
            total_next = total_reg + 1'b1;
            idle_next  = '0;
            case (phase_reg)
                PH_HUNT:
                begin
                    if (req.rx_byte == start_marker_reg)
                    begin
                        phase_next  = PH_SIZE_HI;
                        size_next   = '0;
                        opcode_next = '0;
                        flag_next   = '0;
                        count_next  = '0;
                    end
                end
                PH_SIZE_HI:
                begin
                    size_next  = {req.rx_byte, byte_t'(0)};
                    phase_next = PH_SIZE_LO;
                end
                PH_SIZE_LO:
                begin
                    size_next  = {size_reg[COUNT_W-1:BYTE_W], req.rx_byte};
                    phase_next = PH_OPCODE;
                end
                PH_OPCODE:
                begin
                    opcode_next = req.rx_byte;
                    phase_next  = PH_FLAG;
                end
                PH_FLAG:
                begin
                    flag_next  = req.rx_byte;
                    count_next = '0;
                    if (size_reg == '0)
                    begin
                        // A frame without payload completes on its flag byte.
                        phase_next = PH_HUNT;
                        kind_next  = EV_EMPTY;
                        last_next  = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    kind_next  = EV_DATA;
                    data_next  = req.rx_byte;
                    index_next = count_reg;
                    count_next = count_plus[COUNT_W-1:0];
                    if (count_plus >= {1'b0, size_reg})
                    begin
                        last_next  = 1'b1;
                        phase_next = PH_HUNT;
                        count_next = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        // Header fields show the values after this request, and only with an event.
        if (kind_next == EV_NONE)
        begin
            ev_opcode_next = '0;
            ev_flag_next   = '0;
            ev_size_next   = '0;
        end
        else
        begin
            ev_opcode_next = opcode_next;
            ev_flag_next   = flag_next;
            ev_size_next   = size_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg  <= START_MARKER_RESET;
            timeout_ticks_reg <= TIMEOUT_TICKS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_START_MARKER:  start_marker_reg  <= cfg.data[BYTE_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg.data;
                default:           start_marker_reg  <= start_marker_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            size_reg      <= '0;
            opcode_reg    <= '0;
            flag_reg      <= '0;
            count_reg     <= '0;
            idle_reg      <= '0;
            total_reg     <= '0;
            evt_valid_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            phase_reg     <= phase_next;
            size_reg      <= size_next;
            opcode_reg    <= opcode_next;
            flag_reg      <= flag_next;
            count_reg     <= count_next;
            idle_reg      <= idle_next;
            total_reg     <= total_next;
            evt_valid_reg <= 1'b1;
        end
        else if (evt.ready)
        begin
            evt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg      <= kind_next;
            ev_opcode_reg <= ev_opcode_next;
            ev_flag_reg   <= ev_flag_next;
            ev_size_reg   <= ev_size_next;
            data_reg      <= data_next;
            index_reg     <= index_next;
            last_reg      <= last_next;
        end
    end

`include "serial_command_frame_parser_defines.svh"

    `SCFP_ASSERT_NOW(a_none_fields_zero, evt_valid_reg && kind_reg == EV_NONE, ev_opcode_reg == '0 && ev_flag_reg == '0 && ev_size_reg == '0 && data_reg == '0 && index_reg == '0 && !last_reg)
    `SCFP_ASSERT_NOW(a_last_data_at_end, evt_valid_reg && kind_reg == EV_DATA && last_reg, ({1'b0, index_reg} + 1'b1) == {1'b0, ev_size_reg})
    `SCFP_ASSERT_NEXT(a_byte_clears_idle, req_fire && req.req_type == REQ_BYTE, idle_reg == '0)
    `SCFP_ASSERT_NOW(a_hunt_counters_clear, phase_reg == PH_HUNT, count_reg == '0 && idle_reg == '0)

endmodule
